FILE: hw/rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared constants, command codes and sizing helpers for the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 12;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  // width of one decoded command:
  // op + x + y + err (c+3) + inc_minor (c+3) + inc_major (c+2) + steps + 3 flags
  function automatic int cmd_width(input int c);
    return 6 * c + 12;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// line_rasterizer_core
// Integer line rasterizer for all octants, one pixel per unstalled clock.
// ----------------------------------------------------------------------------
// A start beat (op = 0) loads both endpoints and yields the first pixel; each
// step beat (op = 1) yields the next pixel, with last set on the far endpoint.
// A step with no line in progress yields nothing, and a start abandons any
// line in progress. While the output is not stalled, the block takes one beat
// every clock and gives one pixel every clock: the front does the line setup
// in the input cycle, a two-entry command queue holds it, and the back updates
// the error term and position once per cycle into the output register. Each
// input beat is registered in the queue and then in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_core #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  op,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_end,
  input  wire logic [COORD_BITS-1:0] y_end,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [COORD_BITS-1:0] pixel_x,
  output logic      [COORD_BITS-1:0] pixel_y,
  output logic                       last
);

  localparam int CMD_W = lr_pkg::cmd_width(COORD_BITS);

  logic [CMD_W-1:0] front_cmd;
  logic [CMD_W-1:0] back_cmd;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic             q_push;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  lr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .op      (op),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .cmd     (front_cmd)
  );

  lr_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (front_cmd),
    .pop     (q_pop),
    .rd_data (back_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  lr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last      (last)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front
// Accepts input beats and classifies them. A start beat is turned into the
// full line setup: deltas, step directions, major axis and error terms.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_front #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  wire logic                                   op,
  input  wire logic [COORD_BITS-1:0]                  x_start,
  input  wire logic [COORD_BITS-1:0]                  y_start,
  input  wire logic [COORD_BITS-1:0]                  x_end,
  input  wire logic [COORD_BITS-1:0]                  y_end,
  output logic      [lr_pkg::cmd_width(COORD_BITS)-1:0] cmd
);

  localparam int ERR_W = COORD_BITS + 3;
  localparam int INC_W = COORD_BITS + 2;

  typedef struct packed {
    lr_pkg::op_e             op;
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] inc_minor;
    logic [INC_W-1:0]        inc_major;
    logic [COORD_BITS-1:0]   steps;
    logic                    x_neg;
    logic                    y_neg;
    logic                    x_maj;
  } cmd_t;

  cmd_t                  c;
  logic                  x_neg;
  logic                  y_neg;
  logic                  x_maj;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [COORD_BITS-1:0] dmaj;
  logic [COORD_BITS-1:0] dmin;

  always_comb begin
    x_neg = x_end < x_start;
    y_neg = y_end < y_start;
    dx    = x_neg ? (x_start - x_end) : (x_end - x_start);
    dy    = y_neg ? (y_start - y_end) : (y_end - y_start);
    // equal deltas go to y
    x_maj = dx > dy;
    dmaj  = x_maj ? dx : dy;
    dmin  = x_maj ? dy : dx;

    c.op        = lr_pkg::op_e'(op);
    c.x         = x_start;
    c.y         = y_start;
    c.err       = ERR_W'({2'b00, dmin, 1'b0}) - ERR_W'({3'b000, dmaj});
    c.inc_minor = ERR_W'({2'b00, dmin, 1'b0}) - ERR_W'({2'b00, dmaj, 1'b0});
    c.inc_major = {1'b0, dmin, 1'b0};
    c.steps     = dmaj;
    c.x_neg     = x_neg;
    c.y_neg     = y_neg;
    c.x_maj     = x_maj;
  end

  assign cmd = c;

endmodule

`default_nettype wire

FILE: hw/rtl/lr_queue.sv
// ----------------------------------------------------------------------------
// lr_queue
// Small register queue of decoded commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_queue #(
  parameter int WIDTH = lr_pkg::cmd_width(lr_pkg::COORD_BITS_DEF)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int DEPTH = lr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: hw/rtl/lr_back.sv
// ----------------------------------------------------------------------------
// lr_back
// Holds the line state and carries out one command per unstalled cycle into
// an output register: a start loads the line, a step advances one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_back #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [lr_pkg::cmd_width(COORD_BITS)-1:0] cmd,
  input  wire logic                                   empty,
  output logic                                        pop,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic      [COORD_BITS-1:0]                  pixel_x,
  output logic      [COORD_BITS-1:0]                  pixel_y,
  output logic                                        last
);

  localparam int ERR_W = COORD_BITS + 3;
  localparam int INC_W = COORD_BITS + 2;

  typedef struct packed {
    lr_pkg::op_e             op;
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] inc_minor;
    logic [INC_W-1:0]        inc_major;
    logic [COORD_BITS-1:0]   steps;
    logic                    x_neg;
    logic                    y_neg;
    logic                    x_maj;
  } cmd_t;

  cmd_t c;
  assign c = cmd;

  // line state
  logic                    active;
  logic [COORD_BITS-1:0]   cur_x;
  logic [COORD_BITS-1:0]   cur_y;
  logic signed [ERR_W-1:0] err_term;
  logic signed [ERR_W-1:0] inc_minor_step;
  logic [INC_W-1:0]        inc_major_only;
  logic [COORD_BITS-1:0]   steps_left;
  logic                    x_negative;
  logic                    y_negative;
  logic                    x_major;

  logic                    err_ge;
  logic                    move_x;
  logic                    move_y;
  logic [COORD_BITS-1:0]   x_next;
  logic [COORD_BITS-1:0]   y_next;
  logic signed [ERR_W-1:0] err_next;
  logic [COORD_BITS-1:0]   steps_next;

  assign pop = !empty && (!out_valid || out_ready);

  always_comb begin
    err_ge     = !err_term[ERR_W-1];
    move_x     = x_major || err_ge;
    move_y     = !x_major || err_ge;
    x_next     = move_x ? (x_negative ? cur_x - 1'b1 : cur_x + 1'b1) : cur_x;
    y_next     = move_y ? (y_negative ? cur_y - 1'b1 : cur_y + 1'b1) : cur_y;
    err_next   = err_ge ? err_term + inc_minor_step
                        : err_term + ERR_W'({1'b0, inc_major_only});
    steps_next = steps_left - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a popped start, or a step on a live line, fills the output register
      if (pop && (c.op == lr_pkg::OP_START || active)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        unique case (c.op)
          lr_pkg::OP_START: begin
            active <= c.steps != '0;
          end
          lr_pkg::OP_STEP: begin
            if (active) begin
              active <= steps_next != '0;
            end
          end
          default: begin
            active <= active;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      unique case (c.op)
        lr_pkg::OP_START: begin
          cur_x          <= c.x;
          cur_y          <= c.y;
          err_term       <= c.err;
          inc_minor_step <= c.inc_minor;
          inc_major_only <= c.inc_major;
          steps_left     <= c.steps;
          x_negative     <= c.x_neg;
          y_negative     <= c.y_neg;
          x_major        <= c.x_maj;
          pixel_x        <= c.x;
          pixel_y        <= c.y;
          last           <= c.steps == '0;
        end
        lr_pkg::OP_STEP: begin
          if (active) begin
            cur_x      <= x_next;
            cur_y      <= y_next;
            err_term   <= err_next;
            steps_left <= steps_next;
            pixel_x    <= x_next;
            pixel_y    <= y_next;
            last       <= steps_next == '0;
          end
        end
        default: begin
          cur_x <= cur_x;
        end
      endcase
    end
  end

  a_active_steps: assert property (@(posedge clk) disable iff (rst)
    active |-> steps_left != '0)
    else $error("active line with no steps left");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (pop && c.op == lr_pkg::OP_STEP && !active) |=> !out_valid)
    else $error("step with no line produced a beat");

  a_start_pixel: assert property (@(posedge clk) disable iff (rst)
    (pop && c.op == lr_pkg::OP_START) |=> (out_valid && pixel_x == $past(c.x)
                                           && pixel_y == $past(c.y)))
    else $error("start did not emit its first pixel");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> !active)
    else $error("last pixel while line still active");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for line_rasterizer_core: lines in all octants.
// ----------------------------------------------------------------------------
// A short table of directed beats covers the corners first. These are
// degenerate lines at both ends of the coordinate range, steps with no line
// in progress, equal deltas, and a new start over a line in progress. Random
// lines in random octants follow, of mostly short lengths, with a few long
// ones and some fully random starts. Each beat runs through a local line
// tracer, and every pixel that comes out is checked against the oldest
// expected pixel. The input side idles in bursts, and the output side
// stalls on a changing pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int CW         = lr_pkg::COORD_BITS_DEF;
  localparam int CMAX       = (1 << CW) - 1;
  localparam int BEAT_GOAL  = 1550;
  localparam int DRAIN_WAIT = 8;

  typedef logic [CW-1:0] coord_t;
  typedef logic signed [CW+2:0] err_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_PIXEL,
    CHK_NONE
  } chk_e;

  typedef struct packed {
    lr_pkg::op_e o;
    coord_t      xs;
    coord_t      ys;
    coord_t      xe;
    coord_t      ye;
    chk_e        chk;
    pixel_t      want;
  } stim_row_t;

  localparam int NROWS = 25;
  localparam stim_row_t DIRECTED [NROWS] = '{
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_NONE,  '{   0,    0, 1'b0}},
    '{lr_pkg::OP_START,    0,    0,    0,    0, CHK_PIXEL, '{   0,    0, 1'b1}},
    '{lr_pkg::OP_STEP,  4095, 4095, 4095, 4095, CHK_NONE,  '{   0,    0, 1'b0}},
    '{lr_pkg::OP_START, 4095, 4095, 4095, 4095, CHK_PIXEL, '{4095, 4095, 1'b1}},
    '{lr_pkg::OP_START,    0,    0,    3,    1, CHK_PIXEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_NONE,  '{   0,    0, 1'b0}},
    '{lr_pkg::OP_START, 4095,    0, 4093,    2, CHK_PIXEL, '{4095,    0, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_START,    0, 4095, 4095,    0, CHK_PIXEL, '{   0, 4095, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_START,   10,   10,   10,   12, CHK_PIXEL, '{  10,   10, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_START, 4095,    5, 4094,    5, CHK_PIXEL, '{4095,    5, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_START, 4095, 4095,    0, 4094, CHK_PIXEL, '{4095, 4095, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}},
    '{lr_pkg::OP_START,    2, 4095,    0,    0, CHK_PIXEL, '{   2, 4095, 1'b0}},
    '{lr_pkg::OP_STEP,     0,    0,    0,    0, CHK_MODEL, '{   0,    0, 1'b0}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  lr_pkg::op_e op = lr_pkg::OP_STEP;
  coord_t      x_start = '0;
  coord_t      y_start = '0;
  coord_t      x_end = '0;
  coord_t      y_end = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  coord_t      pixel_x;
  coord_t      pixel_y;
  logic        last;

  line_rasterizer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last      (last)
  );

  always #2 clk = ~clk;

  // line tracer state
  logic   line_active = 1'b0;
  coord_t pos_x = '0;
  coord_t pos_y = '0;
  err_t   decision = '0;
  err_t   inc_diag = '0;
  logic [CW+1:0] inc_straight = '0;
  coord_t pixels_left = '0;
  logic   x_back = 1'b0;
  logic   y_back = 1'b0;
  logic   x_leads = 1'b0;

  pixel_t pending_pixels [$];
  pixel_t got_px;
  pixel_t want_px;

  int mismatches = 0;
  int beats_sent = 0;
  int drawn = 0;
  int idle_steps = 0;
  int lines_started = 0;
  int pixels_checked = 0;
  int burst_left = 1;
  int stall_mode = 0;
  int stall_clock = 0;

  function automatic coord_t nudge(coord_t c, logic back);
    return back ? c - 1'b1 : c + 1'b1;
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(0, CMAX));
  endfunction

  // endpoint at distance d from c where that fits, else the far end of the range
  function automatic coord_t reach(coord_t c, int d);
    bit lo_ok;
    bit hi_ok;
    lo_ok = int'(c) >= d;
    hi_ok = int'(c) + d <= CMAX;
    if (lo_ok && (!hi_ok || $urandom_range(0, 1) == 1)) return coord_t'(int'(c) - d);
    if (hi_ok) return coord_t'(int'(c) + d);
    return (int'(c) > CMAX - int'(c)) ? coord_t'(0) : coord_t'(CMAX);
  endfunction

  // bresenham tracer: advances the line state by one beat
  task automatic trace_line(input lr_pkg::op_e o, input coord_t xs, ys, xe, ye,
                            output bit emits, output pixel_t px);
    coord_t dx;
    coord_t dy;
    coord_t dmaj;
    coord_t dmin;
    emits = 1'b0;
    px = '0;
    if (o == lr_pkg::OP_START) begin
      x_back = xe < xs;
      y_back = ye < ys;
      dx = x_back ? xs - xe : xe - xs;
      dy = y_back ? ys - ye : ye - ys;
      x_leads = dx > dy;
      dmaj = x_leads ? dx : dy;
      dmin = x_leads ? dy : dx;
      pos_x = xs;
      pos_y = ys;
      decision = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
      inc_diag = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
      inc_straight = {1'b0, dmin, 1'b0};
      pixels_left = dmaj;
      line_active = dmaj != '0;
      emits = 1'b1;
    end else if (line_active) begin
      // minor axis moves while the error is not negative
      if (!decision[CW+2]) begin
        if (x_leads) pos_y = nudge(pos_y, y_back);
        else pos_x = nudge(pos_x, x_back);
        decision = decision + inc_diag;
      end else begin
        decision = decision + $signed({1'b0, inc_straight});
      end
      if (x_leads) pos_x = nudge(pos_x, x_back);
      else pos_y = nudge(pos_y, y_back);
      pixels_left = pixels_left - 1'b1;
      line_active = pixels_left != '0;
      emits = 1'b1;
    end
    px = '{pos_x, pos_y, !line_active};
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // drive one beat, wait for acceptance, then trace it and queue the pixel
  task automatic present_beat(input lr_pkg::op_e o, input coord_t xs, ys, xe, ye,
                              input chk_e chk, input pixel_t want);
    bit emits;
    pixel_t px;
    int gap;
    in_valid <= 1'b1;
    op <= o;
    x_start <= xs;
    y_start <= ys;
    x_end <= xe;
    y_end <= ye;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (o == lr_pkg::OP_START) lines_started++;
    trace_line(o, xs, ys, xe, ye, emits, px);
    if (emits) drawn++;
    else idle_steps++;
    if (chk == CHK_PIXEL) pending_pixels.push_back(want);
    else if (chk == CHK_MODEL && emits) pending_pixels.push_back(px);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // output stall pattern: free running, coin flip, sparse, or periodic
  always @(posedge clk) begin
    stall_clock <= stall_clock + 1;
    if (stall_clock % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1) == 1;
      2: out_ready <= $urandom_range(0, 3) == 0;
      default: out_ready <= (stall_clock % 11) < 6;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_px = '{pixel_x, pixel_y, last};
      if (pending_pixels.size() == 0) begin
        flag_mismatch("unexpected pixel x", got_px.x, -1);
      end else begin
        want_px = pending_pixels.pop_front();
        pixels_checked++;
        if (got_px.x !== want_px.x) flag_mismatch("pixel_x", got_px.x, want_px.x);
        if (got_px.y !== want_px.y) flag_mismatch("pixel_y", got_px.y, want_px.y);
        if (got_px.last !== want_px.last) flag_mismatch("last", got_px.last, want_px.last);
      end
    end
  end

  initial begin
    #400000;
    $display("timeout with %0d pixels still pending", pending_pixels.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int len;
    int side;
    int dxm;
    int dym;
    int steps;
    int roll;
    coord_t xs;
    coord_t ys;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NROWS; i++) begin
      present_beat(DIRECTED[i].o, DIRECTED[i].xs, DIRECTED[i].ys, DIRECTED[i].xe,
                   DIRECTED[i].ye, DIRECTED[i].chk, DIRECTED[i].want);
    end

    while (drawn < BEAT_GOAL) begin
      roll = $urandom_range(0, 15);
      if (roll == 0) begin
        // fully random endpoints, usually abandoned early
        present_beat(lr_pkg::OP_START, rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), CHK_MODEL, '0);
        steps = $urandom_range(0, 8);
      end else begin
        len = ($urandom_range(0, 31) == 0) ? $urandom_range(25, CMAX)
                                           : $urandom_range(0, 24);
        side = $urandom_range(0, len);
        if ($urandom_range(0, 1) == 1) begin
          dxm = len;
          dym = side;
        end else begin
          dxm = side;
          dym = len;
        end
        xs = rand_coord();
        ys = rand_coord();
        present_beat(lr_pkg::OP_START, xs, ys, reach(xs, dxm), reach(ys, dym),
                     CHK_MODEL, '0);
        roll = $urandom_range(0, 19);
        if (len > 40) steps = $urandom_range(0, 40);
        else if (roll < 15) steps = len;
        else if (roll < 18) steps = $urandom_range(0, len);
        else steps = len + $urandom_range(1, 3);
      end
      // step beats carry junk on the unused coordinate fields
      repeat (steps) begin
        present_beat(lr_pkg::OP_STEP, rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), CHK_MODEL, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d beats (%0d directed): %0d lines, %0d steps with no line in progress",
             beats_sent, NROWS, lines_started, idle_steps);
    $display("checked %0d pixels, %0d mismatches", pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/lr_pkg.sv
hw/rtl/lr_front.sv
hw/rtl/lr_queue.sv
hw/rtl/lr_back.sv
hw/rtl/line_rasterizer_core.sv
tb/tb.sv
